FILE: hdl/berd_pkg.sv
// ============================================================================
// berd_pkg
// shared constants, types and helpers for the button edge / repeat /
// direction decoder
// ============================================================================
package berd_pkg;

    // button vector
    localparam int NUM_BUTTONS = 30;
    localparam int BTN_W       = 30;
    localparam int KEY_W       = 5;
    localparam int CNT_W       = 5;
    localparam int DIR_W       = 4;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;

    // auto-repeat counter
    localparam logic [CNT_W-1:0] REPEAT_START  = CNT_W'(16);
    localparam logic [CNT_W-1:0] REPEAT_WRAP   = CNT_W'(19);
    localparam logic [CNT_W-1:0] REPEAT_FIRST  = CNT_W'(1);
    localparam int               REPEAT_PERIOD = 4;
    localparam logic [CNT_W-1:0] REPEAT_MOD    = CNT_W'(REPEAT_PERIOD - 1);

    // direction button indexes
    localparam int BTN_DOWN  = 2;
    localparam int BTN_LEFT  = 4;
    localparam int BTN_RIGHT = 6;
    localparam int BTN_UP    = 8;

    // keypad direction codes
    localparam logic [DIR_W-1:0] DIR_NONE       = DIR_W'(0);
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = DIR_W'(1);
    localparam logic [DIR_W-1:0] DIR_DOWN       = DIR_W'(2);
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = DIR_W'(3);
    localparam logic [DIR_W-1:0] DIR_LEFT       = DIR_W'(4);
    localparam logic [DIR_W-1:0] DIR_RIGHT      = DIR_W'(6);
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = DIR_W'(7);
    localparam logic [DIR_W-1:0] DIR_UP         = DIR_W'(8);
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = DIR_W'(9);

    // auto-repeat tracking state
    typedef struct packed {
        logic [KEY_W-1:0] held_key;
        logic [CNT_W-1:0] hold_count;
    } t_rep_state;

    // valid button bits: the low NUM_BUTTONS, bit 0 excluded
    function automatic logic [BTN_W-1:0] f_btn_mask();
        logic [BTN_W-1:0] m;
        for (int i = 0; i < BTN_W; i++) begin
            m[i] = (i < NUM_BUTTONS) && (i != 0);
        end
        return m;
    endfunction

    localparam logic [BTN_W-1:0] BTN_MASK = f_btn_mask();

endpackage

FILE: hdl/berd_repeat.sv
// ============================================================================
// berd_repeat
// edge detect, held key selection and auto-repeat counter update
// ============================================================================
module berd_repeat
    import berd_pkg::*;
(
    input  logic [BTN_W-1:0] i_cur,
    input  logic [BTN_W-1:0] i_prev,
    input  t_rep_state       i_state,
    output logic [BTN_W-1:0] o_trigger,
    output t_rep_state       o_state,
    output logic             o_repeat_valid
);

    logic [BTN_W-1:0] trig;
    logic [KEY_W-1:0] top_idx;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_n;

    assign trig      = i_cur & ~i_prev;
    assign o_trigger = trig;

    // highest newly pressed button
    always_comb begin
        top_idx = '0;
        for (int i = 1; i < BTN_W; i++) begin
            if (trig[i]) begin
                top_idx = KEY_W'(i);
            end
        end
    end

    always_comb begin
        key = (trig != '0) ? top_idx : i_state.held_key;
        cnt = (trig != '0) ? '0 : i_state.hold_count;
        if (i_cur[key]) begin
            cnt_n = (cnt >= REPEAT_WRAP) ? REPEAT_START : cnt + CNT_W'(1);
            o_state.held_key = key;
        end else begin
            cnt_n = '0;
            o_state.held_key = '0;
        end
        o_state.hold_count = cnt_n;
    end

    assign o_repeat_valid = (cnt_n == REPEAT_FIRST) ||
                            ((cnt_n >= REPEAT_START) && ((cnt_n & REPEAT_MOD) == '0));

endmodule

FILE: hdl/berd_dir.sv
// ============================================================================
// berd_dir
// 8-way keypad and 4-way direction decode with diagonal axis memory
// ============================================================================
module berd_dir
    import berd_pkg::*;
(
    input  logic [BTN_W-1:0] i_cur,
    input  logic             i_sideways,
    output logic             o_sideways,
    output logic [DIR_W-1:0] o_dir4,
    output logic [DIR_W-1:0] o_dir8
);

    logic left, right, up, down;
    logic horiz, vert;

    // opposite buttons cancel
    assign left  = i_cur[BTN_LEFT]  & ~i_cur[BTN_RIGHT];
    assign right = i_cur[BTN_RIGHT] & ~i_cur[BTN_LEFT];
    assign up    = i_cur[BTN_UP]    & ~i_cur[BTN_DOWN];
    assign down  = i_cur[BTN_DOWN]  & ~i_cur[BTN_UP];
    assign horiz = left | right;
    assign vert  = up | down;

    always_comb begin
        if (left) begin
            o_dir8 = up ? DIR_UP_LEFT : (down ? DIR_DOWN_LEFT : DIR_LEFT);
        end else if (right) begin
            o_dir8 = up ? DIR_UP_RIGHT : (down ? DIR_DOWN_RIGHT : DIR_RIGHT);
        end else begin
            o_dir8 = up ? DIR_UP : (down ? DIR_DOWN : DIR_NONE);
        end
    end

    always_comb begin
        o_sideways = i_sideways;
        o_dir4     = DIR_NONE;
        if (horiz && vert) begin
            // diagonal: keep the axis opposite to the last single axis
            if (!i_sideways) begin
                o_dir4 = left ? DIR_LEFT : DIR_RIGHT;
            end else begin
                o_dir4 = up ? DIR_UP : DIR_DOWN;
            end
        end else if (horiz) begin
            o_sideways = 1'b1;
            o_dir4     = left ? DIR_LEFT : DIR_RIGHT;
        end else if (vert) begin
            o_sideways = 1'b0;
            o_dir4     = up ? DIR_UP : DIR_DOWN;
        end
    end

endmodule

FILE: hdl/button_edge_repeat_and_direction.sv
// ============================================================================
// button_edge_repeat_and_direction
// per-frame button edge detect, auto-repeat tracking and direction decode
// ============================================================================
// pipeline: input register, then result register; the state update happens
//   on the edge that loads the result register
// throughput: one transaction per cycle, sustained while the result stream
//   accepts, set by the single pass of decode logic between the input
//   register and the result register
// reset (synchronous, active low): pipeline empty, previous buttons, held
//   key, hold counter and axis memory all cleared
module button_edge_repeat_and_direction
    import berd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [29:0] buttons, [31:30] zero
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // [29:0] pressed_mask,
                                                    // [59:30] trigger_mask,
                                                    // [64:60] repeat_key,
                                                    // [65] repeat_valid,
                                                    // [69:66] dir4, [73:70] dir8,
                                                    // [79:74] zero
);

    // input register
    logic             r_in_valid;
    logic [BTN_W-1:0] r_in_buttons;

    // frame state
    logic [BTN_W-1:0] r_prev;
    t_rep_state       r_rep;
    logic             r_sideways;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // decode outputs
    logic [BTN_W-1:0] cur;
    logic [BTN_W-1:0] trigger;
    t_rep_state       n_rep;
    logic             repeat_valid;
    logic             n_sideways;
    logic [DIR_W-1:0] dir4;
    logic [DIR_W-1:0] dir8;
    logic [OUT_TDATA_W-1:0] n_out_data;

    // the input register moves on when the result register is free or drains
    logic advance;
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // bit 0 and any bits beyond the button count never take part
    assign cur = r_in_buttons & BTN_MASK;

    berd_repeat u_repeat (
        .i_cur          (cur),
        .i_prev         (r_prev),
        .i_state        (r_rep),
        .o_trigger      (trigger),
        .o_state        (n_rep),
        .o_repeat_valid (repeat_valid)
    );

    berd_dir u_dir (
        .i_cur      (cur),
        .i_sideways (r_sideways),
        .o_sideways (n_sideways),
        .o_dir4     (dir4),
        .o_dir8     (dir8)
    );

    assign n_out_data = {6'd0, dir8, dir4, repeat_valid, n_rep.held_key, trigger, cur};

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_buttons <= i_s_axis_tdata[BTN_W-1:0];
        end
    end

    // frame state advances once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_rep      <= '0;
            r_sideways <= 1'b0;
        end else if (advance) begin
            r_prev     <= cur;
            r_rep      <= n_rep;
            r_sideways <= n_sideways;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // hold counter never leaves its 0..19 range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep.hold_count <= REPEAT_WRAP)
        else $error("hold counter out of range");

    // a tracked key has always been counted at least once
    a_held_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rep.held_key != '0) |-> (r_rep.hold_count != '0))
        else $error("held key with zero count");

    // newly pressed buttons are a subset of pressed buttons
    a_trig_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[2*BTN_W-1:BTN_W] & ~r_out_data[BTN_W-1:0]) == '0))
        else $error("trigger outside pressed mask");

    // a repeat always names a key
    a_repeat_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[2*BTN_W+KEY_W]) |->
        (r_out_data[2*BTN_W+KEY_W-1:2*BTN_W] != '0))
        else $error("repeat without key");

    // 4-way and 8-way agree on whether there is a direction
    a_dir_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[2*BTN_W+KEY_W+DIR_W:2*BTN_W+KEY_W+1] == DIR_NONE) ==
                         (r_out_data[2*BTN_W+KEY_W+2*DIR_W:2*BTN_W+KEY_W+DIR_W+1] == DIR_NONE)))
        else $error("direction outputs disagree");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// checks the button edge / auto-repeat / direction decoder against an
// in-bench predictor: directed corner frames, held-key repeat sequences,
// randomized traffic with idling on both stream sides, and a long output
// hold-off that backs the block up into its input
// ============================================================================
module testbench;
    import berd_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int HOLD_OFF_LEN  = 300;   // long receiver hold-off for back-pressure
    localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
    localparam int DRAIN_CYCLES  = 8;     // settle time after the last expected result

    // one expected result, fields in the order of the result tdata
    typedef struct packed {
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] trigger;
        logic [KEY_W-1:0] repeat_key;
        logic             repeat_fire;
        logic [DIR_W-1:0] dir4;
        logic [DIR_W-1:0] dir8;
    } t_frame_result;

    // dut ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // [29:0] buttons, [31:30] zero
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // [29:0] pressed, [59:30] trigger,
                                                   // [64:60] repeat_key,
                                                   // [65] repeat_valid,
                                                   // [69:66] dir4, [73:70] dir8

    // predictor state, mirrors the block after reset
    logic [BTN_W-1:0] prev_pressed    = '0;
    logic [KEY_W-1:0] track_key       = '0;
    logic [CNT_W-1:0] track_count     = '0;
    logic             axis_horizontal = 1'b0;

    // results still owed by the block, oldest first
    t_frame_result expected_frames[$];

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // hold-off request: the receiver process notices a new token and counts
    int hold_off_token = 0;
    int hold_off_seen  = 0;
    int hold_off_left  = 0;

    // bookkeeping
    int               frames_sent    = 0;
    int               frames_checked = 0;
    int               repeats_seen   = 0;
    int               mismatch_count = 0;
    int               idle_cycles    = 0;
    logic [BTN_W-1:0] last_buttons   = '0;

    button_edge_repeat_and_direction u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor: one frame in, one result out, state advanced in place
    // ------------------------------------------------------------------------
    function automatic t_frame_result predict_frame(input logic [BTN_W-1:0] raw);
        t_frame_result    r;
        logic [BTN_W-1:0] cur;
        logic [BTN_W-1:0] trig;
        int               lr;
        int               ud;
        cur  = raw & BTN_MASK;
        trig = cur & ~prev_pressed;

        // highest newly pressed button takes over the repeat tracking
        if (trig != '0) begin
            for (int i = 0; i < BTN_W; i++) begin
                if (trig[i]) track_key = KEY_W'(i);
            end
            track_count = '0;
        end
        // held key still down: count on, bounded 16..19 once past the start
        if (cur[track_key]) begin
            track_count = (track_count >= REPEAT_WRAP) ? REPEAT_START
                                                       : track_count + 1'b1;
        end else begin
            track_key   = '0;
            track_count = '0;
        end
        r.repeat_fire = (track_count == REPEAT_FIRST) ||
                        (track_count >= REPEAT_START && (track_count % REPEAT_PERIOD) == 0);

        // opposite buttons on one axis cancel
        lr = int'(cur[BTN_RIGHT]) - int'(cur[BTN_LEFT]);
        ud = int'(cur[BTN_DOWN])  - int'(cur[BTN_UP]);
        if (lr < 0)       r.dir8 = (ud < 0) ? DIR_UP_LEFT  : (ud == 0) ? DIR_LEFT  : DIR_DOWN_LEFT;
        else if (lr == 0) r.dir8 = (ud < 0) ? DIR_UP       : (ud > 0)  ? DIR_DOWN  : DIR_NONE;
        else              r.dir8 = (ud < 0) ? DIR_UP_RIGHT : (ud == 0) ? DIR_RIGHT : DIR_DOWN_RIGHT;

        // diagonal keeps the axis opposite to the one last seen alone;
        // single axis updates it
        if (lr != 0 && ud != 0) begin
            if (!axis_horizontal) ud = 0;
            else                  lr = 0;
        end else if (lr != 0) begin
            axis_horizontal = 1'b1;
        end else if (ud != 0) begin
            axis_horizontal = 1'b0;
        end
        if (lr < 0)      r.dir4 = DIR_LEFT;
        else if (ud < 0) r.dir4 = DIR_UP;
        else if (lr > 0) r.dir4 = DIR_RIGHT;
        else if (ud > 0) r.dir4 = DIR_DOWN;
        else             r.dir4 = DIR_NONE;

        r.pressed    = cur;
        r.trigger    = trig;
        r.repeat_key = track_key;
        prev_pressed = cur;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender: offers one frame, returns at the edge that accepts it.
    // valid stays high after the transaction so back-to-back frames need no
    // second assignment in one time step; an idle gap lowers it first
    // ------------------------------------------------------------------------
    task automatic send_frame(input logic [BTN_W-1:0] buttons);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - BTN_W){1'b0}}, buttons};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_frames.push_back(predict_frame(buttons));
        frames_sent++;
        last_buttons = buttons;
    endtask

    // ------------------------------------------------------------------------
    // receiver ready: random stalls, or a counted hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off_token != hold_off_seen) begin
            hold_off_seen = hold_off_token;
            hold_off_left = HOLD_OFF_LEN;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every output transaction against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected 0x%0h actual 0x%0h", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t mismatch: result transaction 0x%0h with none expected",
                         $realtime, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                check_field("pressed_mask", 32'(want.pressed),
                            32'(o_m_axis_tdata[29:0]));
                check_field("trigger_mask", 32'(want.trigger),
                            32'(o_m_axis_tdata[59:30]));
                check_field("repeat_key",   32'(want.repeat_key),
                            32'(o_m_axis_tdata[64:60]));
                check_field("repeat_valid", 32'(want.repeat_fire),
                            32'(o_m_axis_tdata[65]));
                check_field("dir4",         32'(want.dir4),
                            32'(o_m_axis_tdata[69:66]));
                check_field("dir8",         32'(want.dir8),
                            32'(o_m_axis_tdata[73:70]));
                frames_checked++;
                if (want.repeat_fire) repeats_seen++;
            end
        end
    end

    // watchdog: too long without a transaction on either side ends the run
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, bit 0 masking, every direction, opposites and diagonals
    task automatic test_corner_frames();
        send_frame('0);
        send_frame({BTN_W{1'b1}});                           // everything, top key held
        send_frame({BTN_W{1'b1}});
        send_frame(BTN_W'(1));                               // bit 0 alone reads as nothing
        send_frame('0);
        send_frame(BTN_W'(1) << BTN_LEFT);                   // horizontal seen last
        send_frame((BTN_W'(1) << BTN_LEFT) | (BTN_W'(1) << BTN_DOWN));
        send_frame(BTN_W'(1) << BTN_DOWN);                   // vertical seen last
        send_frame((BTN_W'(1) << BTN_LEFT) | (BTN_W'(1) << BTN_DOWN));
        send_frame((BTN_W'(1) << BTN_LEFT) | (BTN_W'(1) << BTN_RIGHT));
        send_frame((BTN_W'(1) << BTN_DOWN) | (BTN_W'(1) << BTN_UP));
        send_frame(BTN_W'(1) << BTN_UP);
        send_frame(BTN_W'(1) << BTN_RIGHT);
        send_frame((BTN_W'(1) << BTN_RIGHT) | (BTN_W'(1) << BTN_UP));
        send_frame((BTN_W'(1) << BTN_RIGHT) | (BTN_W'(1) << BTN_DOWN));
        send_frame((BTN_W'(1) << BTN_LEFT) | (BTN_W'(1) << BTN_UP));
        send_frame((BTN_W'(1) << BTN_LEFT) | (BTN_W'(1) << BTN_RIGHT) |
                   (BTN_W'(1) << BTN_UP)   | (BTN_W'(1) << BTN_DOWN));
        send_frame(BTN_W'(30'h2AAA_AAAA));
        send_frame(BTN_W'(30'h1555_5555));
        send_frame(BTN_W'(1) << (BTN_W - 1));
        send_frame('0);
    endtask

    // one key held past the counter wrap, then taken over and released
    task automatic test_repeat_wrap();
        logic [BTN_W-1:0] low_key;
        logic [BTN_W-1:0] high_key;
        low_key  = BTN_W'(1) << 5;
        high_key = BTN_W'(1) << 12;
        repeat (26) send_frame(low_key);
        repeat (6)  send_frame(low_key | high_key);  // higher key takes the tracking
        send_frame(low_key);                          // tracked key up: tracking clears
        send_frame('0);
    endtask

    // mixed traffic: mostly held-key runs with random background, some noise
    task automatic test_random_traffic(input int n_frames, input int send_pct,
                                       input int recv_pct);
        int               stop_at;
        int               run_len;
        int               key;
        logic [BTN_W-1:0] frame;
        logic [BTN_W-1:0] flips;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at        = frames_sent + n_frames;
        while (frames_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    // well-formed hold: key goes up, comes down, stays down
                    key     = $urandom_range(1, BTN_W - 1);
                    run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45)
                                                          : $urandom_range(1, 20);
                    frame   = last_buttons & ~(BTN_W'(1) << key);
                    send_frame(frame);
                    repeat (run_len) begin
                        flips = BTN_W'($urandom & $urandom & $urandom);
                        if ($urandom_range(0, 7) != 0)
                            flips &= (BTN_W'(1) << key) - 1'b1;  // keep higher keys quiet
                        frame = (frame ^ flips) | (BTN_W'(1) << key);
                        send_frame(frame);
                    end
                end
                6, 7: begin
                    // direction pad churn over a sparse background
                    repeat ($urandom_range(1, 8)) begin
                        frame = BTN_W'($urandom & $urandom & $urandom);
                        frame[BTN_DOWN]  = 1'($urandom_range(0, 1));
                        frame[BTN_LEFT]  = 1'($urandom_range(0, 1));
                        frame[BTN_RIGHT] = 1'($urandom_range(0, 1));
                        frame[BTN_UP]    = 1'($urandom_range(0, 1));
                        send_frame(frame);
                    end
                end
                8:       send_frame(BTN_W'($urandom));   // full noise
                default: send_frame('0);                 // everything released
            endcase
        end
    endtask

    // receiver holds off for a long stretch while frames keep coming
    task automatic test_output_backpressure();
        logic [BTN_W-1:0] frame;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_token++;
        frame = BTN_W'(1) << 17;
        repeat (40) begin
            frame = (frame ^ BTN_W'($urandom & $urandom & $urandom & $urandom)) |
                    (BTN_W'(1) << 17);
            send_frame(frame);
        end
        send_frame('0);
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_frames();
        test_repeat_wrap();
        test_random_traffic(220, 29, 51);
        test_random_traffic(220, 51, 29);
        test_random_traffic(220, 0, 0);
        test_output_backpressure();

        i_s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d frames: corner frames, held-key wrap, random traffic under",
                 frames_sent);
        $display("three idling mixes and a long output hold-off; %0d results, %0d repeats",
                 frames_checked, repeats_seen);
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/berd_pkg.sv
hdl/berd_repeat.sv
hdl/berd_dir.sv
hdl/button_edge_repeat_and_direction.sv
dv/testbench.sv
